// File: rtl/request_ring_with_progress_pointer_assert.svh
// ----------------------------------------------------------------------------
// Request ring assertion macros
// Shorthand for clocked assertions on clk, disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef REQUEST_RING_WITH_PROGRESS_POINTER_ASSERT_SVH
`define REQUEST_RING_WITH_PROGRESS_POINTER_ASSERT_SVH

// same-cycle implication
`define RRPP_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define RRPP_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/rrpp_pkg.sv
// ----------------------------------------------------------------------------
// Request ring package
// Sizes, command and status codes, payload beats and controller links.
// ----------------------------------------------------------------------------
package rrpp_pkg;

	localparam int RING_BYTES   = 4096;
	localparam int HEADER_BYTES = 4;
	localparam int PTR_W        = $clog2(RING_BYTES);
	localparam int FLEFT_W      = PTR_W + 1;
	localparam int SIZE_W       = 16;
	localparam int LEN_W        = 17;
	localparam int ADV_W        = 17;
	localparam int HDR_SEL_W    = $clog2(HEADER_BYTES);
	localparam logic [ADV_W-1:0] ADV_RESET = ADV_W'(4096);

	localparam logic [2:0] OP_HEADER      = 3'd0;
	localparam logic [2:0] OP_DATA        = 3'd1;
	localparam logic [2:0] OP_FETCH_START = 3'd2;
	localparam logic [2:0] OP_FETCH_BYTE  = 3'd3;
	localparam logic [2:0] OP_QUERY       = 3'd4;

	localparam logic [2:0] ST_OK         = 3'd0;
	localparam logic [2:0] ST_NOSPACE    = 3'd1;
	localparam logic [2:0] ST_EMPTY      = 3'd2;
	localparam logic [2:0] ST_UNFINISHED = 3'd3;
	localparam logic [2:0] ST_SEQ        = 3'd4;

	typedef struct packed {
		logic [2:0]        op;
		logic [SIZE_W-1:0] request_size;
		logic [7:0]        data_byte;
	} in_t;

	typedef struct packed {
		logic [2:0]         status;
		logic [FLEFT_W-1:0] fetch_size;
		logic [7:0]         read_byte;
		logic               last;
		logic               ring_empty;
	} out_t;

	typedef struct packed {
		logic                 clear;
		logic                 accept;
		logic                 decide;
		logic                 hdr_wr;
		logic [HDR_SEL_W-1:0] byte_sel;
		logic                 fclr;
		logic                 emit;
	} rrpp_cmd_t;

	typedef struct packed {
		logic clr_last;
		logic hdr_go;
		logic fbyte_go;
	} rrpp_sts_t;

endpackage

// File: rtl/rrpp_ctrl.sv
// ----------------------------------------------------------------------------
// Request ring controller
// Sequences the memory clear, command decision, header writes and drains.
// ----------------------------------------------------------------------------
module rrpp_ctrl
	import rrpp_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	output logic      busy,
	input  rrpp_sts_t sts,
	output rrpp_cmd_t cmd
);

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_DECIDE,
		S_HDR,
		S_FCLR,
		S_RESP
	} state_t;

	state_t               state_q;
	logic                 busy_q;
	logic [HDR_SEL_W-1:0] cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			busy_q  <= 1'b1;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				S_CLEAR: begin
					if (sts.clr_last) begin
						state_q <= S_IDLE;
						busy_q  <= 1'b0;
					end
				end
				S_IDLE: begin
					if (start) begin
						state_q <= S_DECIDE;
						busy_q  <= 1'b1;
					end
				end
				S_DECIDE: begin
					cnt_q <= '0;
					if (sts.hdr_go) begin
						state_q <= S_HDR;
					end else if (sts.fbyte_go) begin
						state_q <= S_FCLR;
					end else begin
						state_q <= S_RESP;
					end
				end
				S_HDR: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == HDR_SEL_W'(HEADER_BYTES - 1)) begin
						state_q <= S_RESP;
					end
				end
				S_FCLR: begin
					state_q <= S_RESP;
				end
				S_RESP: begin
					state_q <= S_IDLE;
					busy_q  <= 1'b0;
				end
				default: begin
					state_q <= S_CLEAR;
					busy_q  <= 1'b1;
				end
			endcase
		end
	end

	assign busy = busy_q;

	always_comb begin
		cmd          = '0;
		cmd.byte_sel = cnt_q;
		cmd.clear    = (state_q == S_CLEAR);
		cmd.accept   = (state_q == S_IDLE) && start;
		cmd.decide   = (state_q == S_DECIDE);
		cmd.hdr_wr   = (state_q == S_HDR);
		cmd.fclr     = (state_q == S_FCLR);
		cmd.emit     = (state_q == S_RESP);
	end

endmodule

// File: rtl/rrpp_datapath.sv
// ----------------------------------------------------------------------------
// Request ring datapath
// Ring memory, pointers, record length checks and the result register.
// ----------------------------------------------------------------------------
module rrpp_datapath
	import rrpp_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  in_t              item,
	input  logic             cfg_valid,
	input  logic [ADV_W-1:0] cfg_data,
	input  rrpp_cmd_t        cmd,
	output rrpp_sts_t        sts,
	output logic             done,
	output out_t             result
);

	logic [7:0] mem [RING_BYTES];

	in_t                item_q;
	logic [ADV_W-1:0]   max_adv_q;
	logic [PTR_W-1:0]   head_q, tail_q, prog_q, wptr_q, rptr_q, rend_q, pend_q;
	logic [PTR_W-1:0]   mem_addr_q;
	logic [SIZE_W-1:0]  dleft_q;
	logic               ins_open_q;
	logic [FLEFT_W-1:0] fleft_q;
	logic               fopen_q;
	logic [LEN_W-1:0]   hdr_len_q;
	logic [2:0]         res_status_q;
	logic [FLEFT_W-1:0] res_fsize_q;
	logic               res_last_q;
	logic               res_rb_q;
	logic [7:0]         rd_q;
	logic               done_q;
	out_t               out_q;

	logic [PTR_W-1:0]   used;
	logic [LEN_W-1:0]   size_ext;
	logic [LEN_W-1:0]   rec_len;
	logic [LEN_W:0]     adv_sum;
	logic [PTR_W:0]     room;
	logic [PTR_W-1:0]   fs_diff;
	logic [FLEFT_W-1:0] fs_n;
	logic [2:0]         status;
	logic               ok;
	logic               hdr_ok, data_ok, fstart_ok, fbyte_ok;

	logic               mem_we, mem_re;
	logic [PTR_W-1:0]   mem_addr;
	logic [7:0]         mem_wd;
	logic [31:0]        len_shift;

	// record length: payload rounded up to the word, plus the length word
	assign used     = tail_q - head_q;
	assign size_ext = LEN_W'(item_q.request_size);
	assign rec_len  = ((size_ext + LEN_W'(HEADER_BYTES - 1)) & ~LEN_W'(HEADER_BYTES - 1))
		+ LEN_W'(HEADER_BYTES);
	assign adv_sum  = (LEN_W + 1)'(used) + (LEN_W + 1)'(rec_len);
	assign room     = (PTR_W + 1)'(RING_BYTES) - (PTR_W + 1)'(used);
	assign fs_diff  = prog_q - head_q;
	assign fs_n     = (fs_diff == '0) ? FLEFT_W'(RING_BYTES) : FLEFT_W'(fs_diff);

	always_comb begin
		unique case (item_q.op)
			OP_HEADER: begin
				if (ins_open_q) begin
					status = ST_UNFINISHED;
				end else if (adv_sum >= (LEN_W + 1)'(max_adv_q)) begin
					status = ST_NOSPACE;
				end else if (rec_len >= LEN_W'(room)) begin
					status = ST_NOSPACE;
				end else begin
					status = ST_OK;
				end
			end
			OP_DATA:        status = ins_open_q ? ST_OK : ST_SEQ;
			OP_FETCH_START: begin
				if (fopen_q) begin
					status = ST_SEQ;
				end else if (tail_q == head_q) begin
					status = ST_EMPTY;
				end else if (tail_q != prog_q) begin
					status = ST_UNFINISHED;
				end else begin
					status = ST_OK;
				end
			end
			OP_FETCH_BYTE:  status = fopen_q ? ST_OK : ST_SEQ;
			OP_QUERY:       status = ST_OK;
			default:        status = ST_SEQ;
		endcase
	end

	assign ok        = (status == ST_OK);
	assign hdr_ok    = ok && (item_q.op == OP_HEADER);
	assign data_ok   = ok && (item_q.op == OP_DATA);
	assign fstart_ok = ok && (item_q.op == OP_FETCH_START);
	assign fbyte_ok  = ok && (item_q.op == OP_FETCH_BYTE);

	assign sts.clr_last = (mem_addr_q == PTR_W'(RING_BYTES - 1));
	assign sts.hdr_go   = hdr_ok;
	assign sts.fbyte_go = fbyte_ok;

	// length word bytes, little-endian; bytes past the fourth are zero
	assign len_shift = 32'(hdr_len_q) >> {cmd.byte_sel, 3'b000};

	always_comb begin
		mem_we   = 1'b0;
		mem_re   = 1'b0;
		mem_addr = mem_addr_q;
		mem_wd   = '0;
		if (cmd.clear || cmd.fclr) begin
			mem_we = 1'b1;
		end else if (cmd.hdr_wr) begin
			mem_we = 1'b1;
			mem_wd = (int'(cmd.byte_sel) < 4) ? len_shift[7:0] : 8'h00;
		end else if (cmd.decide && data_ok) begin
			mem_we   = 1'b1;
			mem_addr = wptr_q;
			mem_wd   = item_q.data_byte;
		end else if (cmd.decide && fbyte_ok) begin
			mem_re   = 1'b1;
			mem_addr = rptr_q;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_addr] <= mem_wd;
		end
		if (mem_re) begin
			rd_q <= mem[mem_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			item_q <= item;
		end
		if (cmd.decide) begin
			res_status_q <= status;
			res_fsize_q  <= fstart_ok ? fs_n : '0;
			res_last_q   <= fbyte_ok && (fleft_q == FLEFT_W'(1));
			res_rb_q     <= fbyte_ok;
		end
		if (cmd.decide && hdr_ok) begin
			hdr_len_q <= rec_len;
		end
		if (cmd.emit) begin
			out_q.status     <= res_status_q;
			out_q.fetch_size <= res_fsize_q;
			out_q.read_byte  <= res_rb_q ? rd_q : 8'h00;
			out_q.last       <= res_last_q;
			out_q.ring_empty <= (head_q == tail_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_adv_q  <= ADV_RESET;
			head_q     <= '0;
			tail_q     <= '0;
			prog_q     <= '0;
			wptr_q     <= '0;
			rptr_q     <= '0;
			rend_q     <= '0;
			pend_q     <= '0;
			dleft_q    <= '0;
			ins_open_q <= 1'b0;
			fleft_q    <= '0;
			fopen_q    <= 1'b0;
			mem_addr_q <= '0;
			done_q     <= 1'b0;
		end else begin
			done_q <= cmd.emit;
			if (cfg_valid) begin
				max_adv_q <= cfg_data;
			end
			if (cmd.clear || cmd.hdr_wr) begin
				mem_addr_q <= mem_addr_q + 1'b1;
			end
			if (cmd.decide) begin
				if (hdr_ok) begin
					mem_addr_q <= tail_q;
					wptr_q     <= tail_q + PTR_W'(HEADER_BYTES);
					tail_q     <= tail_q + rec_len[PTR_W-1:0];
					pend_q     <= rec_len[PTR_W-1:0];
					dleft_q    <= item_q.request_size;
					if (item_q.request_size == '0) begin
						prog_q <= prog_q + rec_len[PTR_W-1:0];
					end else begin
						ins_open_q <= 1'b1;
					end
				end
				if (data_ok) begin
					wptr_q  <= wptr_q + 1'b1;
					dleft_q <= dleft_q - 1'b1;
					// final payload byte closes the record
					if (dleft_q == SIZE_W'(1)) begin
						prog_q     <= prog_q + pend_q;
						ins_open_q <= 1'b0;
					end
				end
				if (fstart_ok) begin
					rptr_q  <= head_q;
					rend_q  <= prog_q;
					fleft_q <= fs_n;
					fopen_q <= 1'b1;
				end
				if (fbyte_ok) begin
					mem_addr_q <= rptr_q;
					rptr_q     <= rptr_q + 1'b1;
					fleft_q    <= fleft_q - 1'b1;
					if (fleft_q == FLEFT_W'(1)) begin
						head_q  <= rend_q;
						fopen_q <= 1'b0;
					end
				end
			end
		end
	end

	assign done   = done_q;
	assign result = out_q;

endmodule

// File: rtl/request_ring_with_progress_pointer.sv
// ----------------------------------------------------------------------------
// Request ring with progress pointer
// Byte ring of length-prefixed records with insert, drain and status commands.
// ----------------------------------------------------------------------------
// After reset the block holds busy high while it zeroes the ring memory,
// one byte per cycle. A command is then taken when start is high and busy
// is low; its result appears on result with done high for a single cycle,
// and cannot be held off. A new command is not taken until the result of
// the last one has been given. An accepted fetch byte reads the byte and
// then clears it, and an accepted insert header writes the four length-word
// bytes one at a time, since they go through the single byte-wide port of
// the ring memory. The configuration register is written on any cycle with
// cfg_valid high; cfg_ready is always high, and it should be written only
// while idle.
module request_ring_with_progress_pointer
	import rrpp_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  in_t              item,
	output logic             done,
	output out_t             result,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [ADV_W-1:0] cfg_data
);

	rrpp_cmd_t cmd;
	rrpp_sts_t sts;

	assign cfg_ready = 1'b1;

	rrpp_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.sts    (sts),
		.cmd    (cmd)
	);

	rrpp_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item),
		.cfg_valid (cfg_valid),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.sts       (sts),
		.done      (done),
		.result    (result)
	);

endmodule

// File: rtl/rrpp_checker.sv
// ----------------------------------------------------------------------------
// Request ring checker
// Port-level properties of the request ring, bound to its top level.
// ----------------------------------------------------------------------------
`include "request_ring_with_progress_pointer_assert.svh"

module rrpp_checker
	import rrpp_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done,
	input out_t result
);

	// an accepted beat raises busy in the cycle after it
	`RRPP_ASSERT_NXT(a_busy_after_accept, start && !busy, busy, "busy low after accept")

	// one result per command, never two in a row
	`RRPP_ASSERT_NXT(a_single_strobe, done, !done, "result strobe held two cycles")

	// a refused command carries no size, byte or last flag
	`RRPP_ASSERT_IMP(a_refused_clean, done && (result.status != ST_OK),
		(result.fetch_size == '0) && (result.read_byte == '0) && !result.last,
		"refused command carries payload")

	// last only ends a successful drain byte, which reports no size
	`RRPP_ASSERT_IMP(a_last_ok, done && result.last,
		(result.status == ST_OK) && (result.fetch_size == '0),
		"last flag on a non-drain result")

endmodule

bind request_ring_with_progress_pointer rrpp_checker u_rrpp_checker (.*);
